### design/cbe_pkg.sv
// shared types and constants for the cobs block encoder
`default_nettype none

package cbe_pkg;

  localparam int MAX_DEPTH_DEF = 255;
  localparam int BPW_DEF       = 8;

  localparam int BYTE_W    = 8;
  localparam int FILL_W    = 8;
  localparam int WORD_W    = 64;
  localparam int COUNT_W   = 4;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [0:0] {
    OP_ENCODE = 1'b0,
    OP_FINISH = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELIMITER   = 1'b0,
    REG_BLOCK_DEPTH = 1'b1
  } cfg_reg_e;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_pend;
    logic store_in;
    logic store_pend;
    logic flush_step;
    logic end_last;
    logic emit_delim;
    logic emit_empty;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_delim;
    logic full;
    logic has_data;
    logic out_free;
    logic flush_done;
  } stat_t;

endpackage

`default_nettype wire

### design/cbe_channels.sv
// valid/ready channel interfaces for input, result and configuration beats
`default_nettype none

interface cbe_in_if;
  import cbe_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BYTE_W-1:0] data_byte;
  logic              append_delimiter;
  modport source (output valid, opcode, data_byte, append_delimiter, input ready);
  modport sink   (input valid, opcode, data_byte, append_delimiter, output ready);
endinterface

interface cbe_out_if;
  import cbe_pkg::*;
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  out_word;
  logic [COUNT_W-1:0] byte_count;
  logic               block_end;
  logic               status;
  logic               last;
  modport source (output valid, out_word, byte_count, block_end, status, last, input ready);
  modport sink   (input valid, out_word, byte_count, block_end, status, last, output ready);
endinterface

interface cbe_cfg_if;
  import cbe_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/cbe_ctrl.sv
// controller state machine: sequences stores, flushes and single-word results
`default_nettype none

module cbe_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_opcode_i,
  input  wire logic          in_append_i,
  output logic               in_ready_o,
  input  wire cbe_pkg::stat_t stat_i,
  output cbe_pkg::cmd_t      cmd_o
);
  import cbe_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FLUSH = 4'b0010,
    ST_DELIM = 4'b0100,
    ST_EMPTY = 4'b1000
  } state_e;

  // what follows the current flush
  typedef enum logic [1:0] {
    AFTER_NONE  = 2'd0,
    AFTER_STORE = 2'd1,
    AFTER_AGAIN = 2'd2,
    AFTER_DELIM = 2'd3
  } after_e;

  state_e state_q, state_d;
  after_e after_q, after_d;

  always_comb begin
    state_d    = state_q;
    after_d    = after_q;
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        cmd_o.load_pend = 1'b1;
        if (in_valid_i) begin
          if (in_opcode_i == OP_FINISH) begin
            if (!stat_i.has_data) begin
              state_d = ST_EMPTY;
            end else begin
              state_d = ST_FLUSH;
              after_d = in_append_i ? AFTER_DELIM : AFTER_NONE;
            end
          end else if (!stat_i.full && !stat_i.is_delim) begin
            cmd_o.store_in = 1'b1;
          end else begin
            state_d = ST_FLUSH;
            if (!stat_i.full) begin
              after_d = AFTER_NONE;
            end else if (stat_i.is_delim) begin
              after_d = AFTER_AGAIN;
            end else begin
              after_d = AFTER_STORE;
            end
          end
        end
      end
      ST_FLUSH: begin
        cmd_o.flush_step = 1'b1;
        cmd_o.end_last   = (after_q == AFTER_NONE) || (after_q == AFTER_STORE);
        if (stat_i.flush_done) begin
          case (after_q)
            AFTER_NONE: state_d = ST_IDLE;
            AFTER_STORE: begin
              cmd_o.store_pend = 1'b1;
              state_d          = ST_IDLE;
            end
            AFTER_AGAIN: after_d = AFTER_NONE;
            AFTER_DELIM: state_d = ST_DELIM;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_DELIM: begin
        cmd_o.emit_delim = 1'b1;
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        cmd_o.emit_empty = 1'b1;
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      after_q <= AFTER_NONE;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
    end
  end

endmodule

`default_nettype wire

### design/cbe_dp.sv
// datapath: config registers, block memory, fill count, word packer, result register
`default_nettype none

module cbe_dp #(
  parameter int MAX_DEPTH      = cbe_pkg::MAX_DEPTH_DEF,
  parameter int BYTES_PER_WORD = cbe_pkg::BPW_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  input  wire logic [cbe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [cbe_pkg::BYTE_W-1:0]      cfg_data_i,
  input  wire logic [cbe_pkg::BYTE_W-1:0]      in_byte_i,
  input  wire cbe_pkg::cmd_t                   cmd_i,
  output cbe_pkg::stat_t                       stat_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [cbe_pkg::WORD_W-1:0]           out_word_o,
  output logic [cbe_pkg::COUNT_W-1:0]          out_count_o,
  output logic                                 out_end_o,
  output logic                                 out_status_o,
  output logic                                 out_last_o
);
  import cbe_pkg::*;

  localparam int MEM_DEPTH = MAX_DEPTH - 1;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [FILL_W-1:0] DEPTH_MIN = FILL_W'(2);
  localparam logic [FILL_W-1:0] DEPTH_MAX = FILL_W'(MAX_DEPTH);
  localparam logic [COUNT_W-1:0] LAST_LANE = COUNT_W'(BYTES_PER_WORD - 1);

  logic [BYTE_W-1:0]  delim_q, depth_q;
  logic [FILL_W-1:0]  fill_q, fill_d, idx_q, idx_d;
  logic [COUNT_W-1:0] pos_q, pos_d;
  logic [WORD_W-1:0]  word_q, word_d, merged;
  logic [BYTE_W-1:0]  pend_q, rd_data_q;
  logic [BYTE_W-1:0]  mem_q [MEM_DEPTH];

  logic [FILL_W-1:0]  depth_eff, fill_m1;
  logic [BYTE_W-1:0]  code_byte, cur_byte, wr_byte;
  logic [AW-1:0]      wr_addr;
  logic               wr_en, rd_en;
  logic               is_last_byte, need_emit, out_free, advance;
  logic               load_flush, load_delim, load_empty;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= '0;
      depth_q <= 8'hFF;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DELIMITER:   delim_q <= cfg_data_i;
        REG_BLOCK_DEPTH: depth_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (depth_q < DEPTH_MIN) begin
      depth_eff = DEPTH_MIN;
    end else if (depth_q > DEPTH_MAX) begin
      depth_eff = DEPTH_MAX;
    end else begin
      depth_eff = depth_q;
    end
  end

  assign fill_m1      = fill_q - FILL_W'(1);
  // code byte zero when the count would itself be the delimiter
  assign code_byte    = ((delim_q != '0) && (fill_q == delim_q)) ? '0 : fill_q;
  assign cur_byte     = (idx_q == '0) ? code_byte : rd_data_q;
  assign is_last_byte = (idx_q == fill_m1);
  assign need_emit    = is_last_byte || (pos_q == LAST_LANE);
  assign out_free     = !out_valid_o || out_ready_i;
  assign advance      = cmd_i.flush_step && (!need_emit || out_free);
  assign load_flush   = advance && need_emit;
  assign load_delim   = cmd_i.emit_delim && out_free;
  assign load_empty   = cmd_i.emit_empty && out_free;

  always_comb begin
    merged = word_q;
    for (int l = 0; l < BYTES_PER_WORD; l++) begin
      if (pos_q == COUNT_W'(l)) begin
        merged[l*BYTE_W +: BYTE_W] = cur_byte;
      end
    end
  end

  // block memory, one write and one registered read port
  assign wr_en   = cmd_i.store_in || cmd_i.store_pend;
  assign wr_addr = cmd_i.store_pend ? '0 : fill_m1[AW-1:0];
  assign wr_byte = cmd_i.store_pend ? pend_q : in_byte_i;
  assign rd_en   = advance && !is_last_byte;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_byte;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[idx_q[AW-1:0]];
    end
    if (cmd_i.load_pend) begin
      pend_q <= in_byte_i;
    end
  end

  always_comb begin
    fill_d = fill_q;
    idx_d  = idx_q;
    pos_d  = pos_q;
    word_d = word_q;
    if (cmd_i.store_in) begin
      fill_d = fill_q + FILL_W'(1);
    end
    if (advance) begin
      if (need_emit) begin
        pos_d  = '0;
        word_d = '0;
      end else begin
        pos_d  = pos_q + COUNT_W'(1);
        word_d = merged;
      end
      if (is_last_byte) begin
        idx_d  = '0;
        fill_d = FILL_W'(1);
      end else begin
        idx_d = idx_q + FILL_W'(1);
      end
    end
    if (cmd_i.store_pend) begin
      fill_d = FILL_W'(2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= FILL_W'(1);
      idx_q  <= '0;
      pos_q  <= '0;
      word_q <= '0;
    end else begin
      fill_q <= fill_d;
      idx_q  <= idx_d;
      pos_q  <= pos_d;
      word_q <= word_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_flush || load_delim || load_empty) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_flush) begin
      out_word_o   <= merged;
      out_count_o  <= pos_q + COUNT_W'(1);
      out_end_o    <= is_last_byte;
      out_status_o <= STATUS_OK;
      out_last_o   <= is_last_byte && cmd_i.end_last;
    end else if (load_delim) begin
      out_word_o   <= WORD_W'(delim_q);
      out_count_o  <= COUNT_W'(1);
      out_end_o    <= 1'b1;
      out_status_o <= STATUS_OK;
      out_last_o   <= 1'b1;
    end else if (load_empty) begin
      out_word_o   <= '0;
      out_count_o  <= '0;
      out_end_o    <= 1'b0;
      out_status_o <= STATUS_EMPTY;
      out_last_o   <= 1'b1;
    end
  end

  assign stat_o.is_delim   = (in_byte_i == delim_q);
  assign stat_o.full       = (fill_q >= depth_eff);
  assign stat_o.has_data   = (fill_q >= DEPTH_MIN);
  assign stat_o.out_free   = out_free;
  assign stat_o.flush_done = advance && is_last_byte;

endmodule

`default_nettype wire

### design/cobs_block_encoder_unit.sv
// top level of the cobs block encoder: controller, datapath and channel ports
//
//  channel | dir | payload                                            | beat when
//  in_i    | in  | opcode, data_byte, append_delimiter                | valid & ready
//  out_o   | out | out_word, byte_count, block_end, status, last      | valid & ready
//  cfg_i   | in  | index (0 delimiter, 1 block_depth), data           | valid & ready
//
// a data byte that is only buffered leaves in_i ready again in the next cycle
// an item that flushes holds in_i off while the flush walks the block byte by byte
// (code byte included) through the single read port of the block memory, and pauses
// while out_o stalls a finished word; a delimiter on a full block flushes twice
// a trailing delimiter or an empty-finish result is loaded from a state of its own
// reset empties the block (count 1, code slot only); the memory needs no clearing
// out_o is registered, so a pending result never blocks buffering of new bytes
`default_nettype none

module cobs_block_encoder_unit #(
  parameter int MAX_DEPTH      = cbe_pkg::MAX_DEPTH_DEF,
  parameter int BYTES_PER_WORD = cbe_pkg::BPW_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cbe_in_if.sink     in_i,
  cbe_out_if.source  out_o,
  cbe_cfg_if.sink    cfg_i
);
  import cbe_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  // config writes are taken at any time
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  // controller decides store versus flush for each beat and what follows a flush
  cbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_append_i (in_i.append_delimiter),
    .in_ready_o  (in_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath holds the block, packs flushed bytes into words and drives out_o
  cbe_dp #(
    .MAX_DEPTH      (MAX_DEPTH),
    .BYTES_PER_WORD (BYTES_PER_WORD)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .in_byte_i    (in_i.data_byte),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_word_o   (out_o.out_word),
    .out_count_o  (out_o.byte_count),
    .out_end_o    (out_o.block_end),
    .out_status_o (out_o.status),
    .out_last_o   (out_o.last)
  );

  // an empty-finish result carries no bytes, ends the input and is no block end
  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == STATUS_EMPTY) |->
      (out_o.byte_count == '0 && out_o.last && !out_o.block_end))
    else $error("empty result with bytes or without last");

  // no input beat is taken while a flush is in progress
  a_no_accept_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !cmd.flush_step)
    else $error("input beat accepted during flush");

  // a buffered byte always leaves the block with data in it
  a_store_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store_in |=> stat.has_data)
    else $error("block empty after storing a byte");

  // a word that closes a block carries at least one byte
  a_end_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.block_end) |-> (out_o.byte_count != '0))
    else $error("block end word without bytes");

endmodule

`default_nettype wire

### tb/tb_cobs_block_encoder_unit.sv
`timescale 1ns / 100ps
// self-checking testbench for the cobs block encoder: directed, stress and random frames

module tb_cobs_block_encoder_unit;
  import cbe_pkg::*;

  // one expected output beat of the encoder
  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count;
    logic               blk_end;
    logic               status;
    logic               last_beat;
  } enc_beat_t;

  logic clk_i;
  logic rst_ni;

  cbe_in_if  in_ch ();
  cbe_out_if out_ch ();
  cbe_cfg_if cfg_ch ();

  cobs_block_encoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // mirror of the encoder state, updated as input beats are accepted
  logic [BYTE_W-1:0] held_bytes [0:MAX_DEPTH_DEF-2];
  int unsigned       held_fill;
  logic [BYTE_W-1:0] cur_delim;
  logic [BYTE_W-1:0] cur_depth;

  // encoded words still owed by the block, oldest first
  enc_beat_t expected_beats[$];

  int unsigned fail_count;
  bit          send_gaps;
  bit          recv_gaps;
  int unsigned stall_left;
  int unsigned hold_left;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // emit the held block as code byte plus data, packed eight bytes per word
  function automatic void flush_held();
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] b;
    logic [WORD_W-1:0] word;
    int unsigned       pos;
    int unsigned       k;
    code = (cur_delim != 0 && held_fill == cur_delim) ? 8'd0 : BYTE_W'(held_fill);
    word = '0;
    pos  = 0;
    for (k = 0; k < held_fill; k++) begin
      b = (k == 0) ? code : held_bytes[k-1];
      word |= WORD_W'(b) << (8 * pos);
      pos++;
      if (pos == BPW_DEF || k + 1 == held_fill) begin
        expected_beats.push_back('{word, COUNT_W'(pos), (k + 1 == held_fill), STATUS_OK, 1'b0});
        word = '0;
        pos  = 0;
      end
    end
    held_fill = 1;
  endfunction

  // work out the words one accepted input beat causes
  function automatic void predict_encoding(opcode_e op, logic [BYTE_W-1:0] b, logic app);
    int unsigned n0;
    int unsigned lim;
    bit          again;
    n0  = expected_beats.size();
    lim = (cur_depth < 2) ? 2 : cur_depth;
    if (op == OP_ENCODE) begin
      again = 1'b1;
      while (again) begin
        if (b != cur_delim && held_fill < lim) begin
          held_bytes[held_fill-1] = b;
          held_fill++;
          again = 1'b0;
        end else begin
          // a delimiter or a full block is flushed; after a full block the byte is tried again
          again = (held_fill >= lim);
          flush_held();
        end
      end
    end else if (held_fill < 2) begin
      expected_beats.push_back('{'0, '0, 1'b0, STATUS_EMPTY, 1'b0});
    end else begin
      flush_held();
      if (app) expected_beats.push_back('{WORD_W'(cur_delim), COUNT_W'(1), 1'b1, STATUS_OK, 1'b0});
    end
    if (expected_beats.size() > n0) expected_beats[expected_beats.size()-1].last_beat = 1'b1;
  endfunction

  // offer one input beat, optionally after a gap, and hold it until accepted
  task automatic send_item(opcode_e op, logic [BYTE_W-1:0] b, logic app);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid            = 1'b1;
    in_ch.opcode           = op;
    in_ch.data_byte        = b;
    in_ch.append_delimiter = app;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_encoding(op, b, app);
    @(negedge clk_i);
  endtask

  task automatic push_payload(logic [BYTE_W-1:0] b);
    send_item(OP_ENCODE, b, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_finish(logic app);
    send_item(OP_FINISH, BYTE_W'($urandom_range(0, 255)), app);
  endtask

  // stop offering input and wait until every owed word has arrived
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    // a byte that is only buffered may still be on its way into the block
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [BYTE_W-1:0] val);
    wait_drained();
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (idx == REG_DELIMITER) cur_delim = val;
    else cur_depth = val;
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // receiver: stalls counted per beat, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // compare each output beat with the oldest owed word
  always @(posedge clk_i) begin
    enc_beat_t got;
    enc_beat_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_word, out_ch.byte_count, out_ch.block_end, out_ch.status, out_ch.last};
      stall_left = recv_gaps ? $urandom_range(0, 13) : 0;
      if (expected_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected beat: word=%h count=%0d end=%b status=%b last=%b",
                   got.word, got.count, got.blk_end, got.status, got.last_beat);
      end else begin
        want = expected_beats.pop_front();
        if (got != want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: exp word=%h count=%0d end=%b status=%b last=%b",
                     want.word, want.count, want.blk_end, want.status, want.last_beat);
            $display("          got word=%h count=%0d end=%b status=%b last=%b",
                     got.word, got.count, got.blk_end, got.status, got.last_beat);
          end
        end
      end
    end
  end

  // reset settings: zero delimiter, deepest block
  task automatic test_reset_config();
    send_finish(1'b1);   // empty finish, no delimiter follows
    push_payload(8'h00);    // delimiter on an empty block gives a lone code byte
    push_payload(8'hFF);
    push_payload(8'h01);
    push_payload(8'h00);
    push_payload(8'h80);
    send_finish(1'b1);
    send_finish(1'b0);
  endtask

  // register extremes, depth values below the legal floor included
  task automatic test_register_extremes();
    write_reg(REG_DELIMITER, 8'hFF);
    write_reg(REG_BLOCK_DEPTH, 8'd0);
    push_payload(8'h00);
    push_payload(8'h7F);    // block already full, flush then keep the byte
    push_payload(8'hFF);
    send_finish(1'b1);
    write_reg(REG_DELIMITER, 8'd3);
    write_reg(REG_BLOCK_DEPTH, 8'd1);
    push_payload(8'h10);
    push_payload(8'h20);
    push_payload(8'h03);
    push_payload(8'h30);
    send_finish(1'b1);
  endtask

  // depth lowered below the current fill, and a code byte that equals the delimiter
  task automatic test_depth_lowered();
    write_reg(REG_DELIMITER, 8'd4);
    write_reg(REG_BLOCK_DEPTH, 8'd6);
    push_payload(8'h01);
    push_payload(8'h02);
    push_payload(8'h03);
    write_reg(REG_BLOCK_DEPTH, 8'd3);
    push_payload(8'h05);    // fill of four equals the delimiter, code goes to zero
    push_payload(8'h04);
    send_finish(1'b0);
    write_reg(REG_BLOCK_DEPTH, 8'd2);
    push_payload(8'hAA);
    send_finish(1'b1);
  endtask

  // receiver holds off while the sender keeps going, so flushes back up the input
  task automatic test_output_stall();
    int i;
    write_reg(REG_DELIMITER, 8'h00);
    write_reg(REG_BLOCK_DEPTH, 8'd3);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    @(posedge clk_i);
    hold_left = 300;
    @(negedge clk_i);
    for (i = 0; i < 40; i++) push_payload(BYTE_W'($urandom_range(1, 255)));
    send_finish(1'b1);
  endtask

  // largest block: a full 255 byte block plus trailing delimiter in one finish
  task automatic test_max_block();
    int i;
    write_reg(REG_DELIMITER, 8'hFF);
    write_reg(REG_BLOCK_DEPTH, 8'd255);
    send_gaps = 1'b0;
    recv_gaps = 1'b1;
    for (i = 0; i < 254; i++) push_payload(BYTE_W'($urandom_range(0, 254)));
    send_finish(1'b1);
  endtask

  // random frames under random settings, small blocks for the most part
  task automatic test_random_frames();
    int          phase;
    int          i;
    int unsigned pick;
    for (phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 3))
        0: write_reg(REG_DELIMITER, 8'h00);
        1: write_reg(REG_DELIMITER, 8'hFF);
        2: write_reg(REG_DELIMITER, BYTE_W'($urandom_range(1, 12)));
        default: write_reg(REG_DELIMITER, BYTE_W'($urandom_range(0, 255)));
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 6) write_reg(REG_BLOCK_DEPTH, BYTE_W'($urandom_range(2, 12)));
      else if (pick == 6) write_reg(REG_BLOCK_DEPTH, BYTE_W'($urandom_range(0, 1)));
      else if (pick == 7) write_reg(REG_BLOCK_DEPTH, 8'd255);
      else write_reg(REG_BLOCK_DEPTH, BYTE_W'($urandom_range(13, 254)));
      send_gaps = 1'($urandom_range(0, 1));
      recv_gaps = 1'($urandom_range(0, 1));
      for (i = 0; i < 16; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) send_finish(1'($urandom_range(0, 1)));
        else if (pick < 20) push_payload(cur_delim);
        else push_payload(BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_ni                 = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.opcode           = OP_ENCODE;
    in_ch.data_byte        = '0;
    in_ch.append_delimiter = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = REG_DELIMITER;
    cfg_ch.data            = '0;
    held_fill              = 1;
    cur_delim              = 8'h00;
    cur_depth              = 8'd255;
    fail_count             = 0;
    stall_left             = 0;
    hold_left              = 0;
    send_gaps              = 1'b1;
    recv_gaps              = 1'b1;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_config();
    test_register_extremes();
    test_depth_lowered();
    test_output_stall();
    test_max_block();
    test_random_frames();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
